@@ design/assert_macros.svh @@
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

@@ design/dpd_pkg.sv @@
package dpd_pkg;

    // Field and datapath widths
    localparam int DIST_W    = 16;
    localparam int GAIN_W    = 16;
    localparam int PER_W     = 10;
    localparam int ERR_W     = DIST_W + 1;
    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = ERR_W;
    localparam int P_W       = MUL_A_W;
    localparam int PROD_W    = 45;
    localparam int INT_W     = 40;
    localparam int SUM_W     = 45;
    localparam int DIVN_W    = 42;
    localparam int DIVD_W    = 10;
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = DIVN_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int CLAMP_W   = 24;
    localparam int FRAC_DROP = 6;
    localparam int CV_W      = 17;
    localparam int SPEED_W   = 8;
    localparam int DIR_W     = 2;

    // Arithmetic constants
    localparam int DIV_CONST   = 1000;
    localparam int BASE_SPEED  = 100;
    localparam int EXTRA_MAX   = 155;
    localparam logic signed [SUM_W-1:0] OUT_LIMIT   = SUM_W'(255 * 16384);
    localparam logic signed [SUM_W-1:0] OUT_LIMIT_N = SUM_W'(-255 * 16384);

    // Drive direction codes
    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BACK = 2'd2;

    // Register map
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;
    localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd5;

    localparam logic [DIST_W-1:0] RST_TARGET = 16'd3200;
    localparam logic [GAIN_W-1:0] RST_GAIN_P = 16'd128;
    localparam logic [GAIN_W-1:0] RST_GAIN_I = 16'd26;
    localparam logic [GAIN_W-1:0] RST_GAIN_D = 16'd256;
    localparam logic [PER_W-1:0]  RST_PERIOD = 10'd100;

    typedef struct packed {
        logic [DIST_W-1:0] target_distance;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [PER_W-1:0]  period_ms;
        logic              run_enable;
    } cfg_t;

    // Datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL_IE  = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL_XP  = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV_I   = 4'd4;
    localparam logic [OP_W-1:0] OP_INT_ACC = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL_P   = 4'd6;
    localparam logic [OP_W-1:0] OP_SUM_PI  = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL_DD  = 4'd8;
    localparam logic [OP_W-1:0] OP_MUL_XK  = 4'd9;
    localparam logic [OP_W-1:0] OP_DIV_D   = 4'd10;
    localparam logic [OP_W-1:0] OP_SUM_D   = 4'd11;
    localparam logic [OP_W-1:0] OP_CLAMP   = 4'd12;
    localparam logic [OP_W-1:0] OP_OUT     = 4'd13;
    localparam logic [OP_W-1:0] OP_OFF     = 4'd14;

    // Jump conditions: jump to target when the condition holds
    localparam int JC_W = 3;
    localparam logic [JC_W-1:0] JC_NEXT     = 3'd0;
    localparam logic [JC_W-1:0] JC_ALWAYS   = 3'd1;
    localparam logic [JC_W-1:0] JC_NO_IN    = 3'd2;
    localparam logic [JC_W-1:0] JC_OFF      = 3'd3;
    localparam logic [JC_W-1:0] JC_DIV_BUSY = 3'd4;
    localparam logic [JC_W-1:0] JC_OUT_FULL = 3'd5;

    // Program labels
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] ST_LOAD  = 5'd0;
    localparam logic [STEP_W-1:0] ST_IWAIT = 5'd5;
    localparam logic [STEP_W-1:0] ST_DWAIT = 5'd12;
    localparam logic [STEP_W-1:0] ST_OUT   = 5'd15;
    localparam logic [STEP_W-1:0] ST_OFF   = 5'd17;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [JC_W-1:0]   jc;
        logic [STEP_W-1:0] tgt;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic enabled;
        logic div_busy;
        logic out_free;
    } status_t;

    // Microprogram ROM
    function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{op: OP_NOP, jc: JC_ALWAYS, tgt: ST_LOAD};
        case (step)
            5'd0:  w = '{op: OP_LOAD,    jc: JC_NO_IN,    tgt: ST_LOAD};
            5'd1:  w = '{op: OP_NOP,     jc: JC_OFF,      tgt: ST_OFF};
            5'd2:  w = '{op: OP_MUL_IE,  jc: JC_NEXT,     tgt: ST_LOAD};
            5'd3:  w = '{op: OP_MUL_XP,  jc: JC_NEXT,     tgt: ST_LOAD};
            5'd4:  w = '{op: OP_DIV_I,   jc: JC_NEXT,     tgt: ST_LOAD};
            5'd5:  w = '{op: OP_NOP,     jc: JC_DIV_BUSY, tgt: ST_IWAIT};
            5'd6:  w = '{op: OP_INT_ACC, jc: JC_NEXT,     tgt: ST_LOAD};
            5'd7:  w = '{op: OP_MUL_P,   jc: JC_NEXT,     tgt: ST_LOAD};
            5'd8:  w = '{op: OP_SUM_PI,  jc: JC_NEXT,     tgt: ST_LOAD};
            5'd9:  w = '{op: OP_MUL_DD,  jc: JC_NEXT,     tgt: ST_LOAD};
            5'd10: w = '{op: OP_MUL_XK,  jc: JC_NEXT,     tgt: ST_LOAD};
            5'd11: w = '{op: OP_DIV_D,   jc: JC_NEXT,     tgt: ST_LOAD};
            5'd12: w = '{op: OP_NOP,     jc: JC_DIV_BUSY, tgt: ST_DWAIT};
            5'd13: w = '{op: OP_SUM_D,   jc: JC_NEXT,     tgt: ST_LOAD};
            5'd14: w = '{op: OP_CLAMP,   jc: JC_NEXT,     tgt: ST_LOAD};
            5'd15: w = '{op: OP_OUT,     jc: JC_OUT_FULL, tgt: ST_OUT};
            5'd16: w = '{op: OP_NOP,     jc: JC_ALWAYS,   tgt: ST_LOAD};
            5'd17: w = '{op: OP_OFF,     jc: JC_OUT_FULL, tgt: ST_OFF};
            5'd18: w = '{op: OP_NOP,     jc: JC_ALWAYS,   tgt: ST_LOAD};
            default: w = '{op: OP_NOP,   jc: JC_ALWAYS,   tgt: ST_LOAD};
        endcase
        return w;
    endfunction

endpackage

@@ design/dpd_sample_if.sv @@
// Measurement item channel
interface dpd_sample_if;
    logic                        valid;
    logic                        ready;
    logic [dpd_pkg::DIST_W-1:0]  distance_cm;

    modport source (output valid, output distance_cm, input ready);
    modport sink   (input valid, input distance_cm, output ready);
endinterface

@@ design/dpd_result_if.sv @@
// Drive command item channel
interface dpd_result_if;
    logic                              valid;
    logic                              ready;
    logic [dpd_pkg::SPEED_W-1:0]       drive_speed;
    logic [dpd_pkg::DIR_W-1:0]         drive_direction;
    logic signed [dpd_pkg::CV_W-1:0]   control_value;

    modport source (output valid, output drive_speed, output drive_direction,
                    output control_value, input ready);
    modport sink   (input valid, input drive_speed, input drive_direction,
                    input control_value, output ready);
endinterface

@@ design/dpd_cfg.sv @@
module dpd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dpd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dpd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dpd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output dpd_pkg::cfg_t                   cfg
);

    dpd_pkg::cfg_t                   cfg_reg;
    dpd_pkg::cfg_t                   cfg_next;
    logic [dpd_pkg::REG_IDX_W-1:0]   idx;
    logic                            wr_en;

    assign idx    = paddr[dpd_pkg::APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                dpd_pkg::REG_TARGET: cfg_next.target_distance = pwdata[dpd_pkg::DIST_W-1:0];
                dpd_pkg::REG_GAIN_P: cfg_next.gain_p = pwdata[dpd_pkg::GAIN_W-1:0];
                dpd_pkg::REG_GAIN_I: cfg_next.gain_i = pwdata[dpd_pkg::GAIN_W-1:0];
                dpd_pkg::REG_GAIN_D: cfg_next.gain_d = pwdata[dpd_pkg::GAIN_W-1:0];
                dpd_pkg::REG_PERIOD: cfg_next.period_ms = pwdata[dpd_pkg::PER_W-1:0];
                dpd_pkg::REG_ENABLE: cfg_next.run_enable = pwdata[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_distance <= dpd_pkg::RST_TARGET;
            cfg_reg.gain_p          <= dpd_pkg::RST_GAIN_P;
            cfg_reg.gain_i          <= dpd_pkg::RST_GAIN_I;
            cfg_reg.gain_d          <= dpd_pkg::RST_GAIN_D;
            cfg_reg.period_ms       <= dpd_pkg::RST_PERIOD;
            cfg_reg.run_enable      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            dpd_pkg::REG_TARGET: prdata = dpd_pkg::APB_DATA_W'(cfg_reg.target_distance);
            dpd_pkg::REG_GAIN_P: prdata = dpd_pkg::APB_DATA_W'(cfg_reg.gain_p);
            dpd_pkg::REG_GAIN_I: prdata = dpd_pkg::APB_DATA_W'(cfg_reg.gain_i);
            dpd_pkg::REG_GAIN_D: prdata = dpd_pkg::APB_DATA_W'(cfg_reg.gain_d);
            dpd_pkg::REG_PERIOD: prdata = dpd_pkg::APB_DATA_W'(cfg_reg.period_ms);
            dpd_pkg::REG_ENABLE: prdata = dpd_pkg::APB_DATA_W'(cfg_reg.run_enable);
            default:             prdata = '0;
        endcase
    end

endmodule

@@ design/dpd_seq.sv @@
module dpd_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  dpd_pkg::status_t  stat,
    output dpd_pkg::ctrl_t    ctrl
);

    logic [dpd_pkg::STEP_W-1:0] step_reg;
    logic [dpd_pkg::STEP_W-1:0] step_next;
    logic                       take;

    // Control word for the current step
    assign ctrl = dpd_pkg::ucode_rom(step_reg);

    // Branch condition
    always_comb
    begin
        case (ctrl.jc)
            dpd_pkg::JC_NEXT:     take = 1'b0;
            dpd_pkg::JC_ALWAYS:   take = 1'b1;
            dpd_pkg::JC_NO_IN:    take = !stat.in_valid;
            dpd_pkg::JC_OFF:      take = !stat.enabled;
            dpd_pkg::JC_DIV_BUSY: take = stat.div_busy;
            dpd_pkg::JC_OUT_FULL: take = !stat.out_free;
            default:              take = 1'b0;
        endcase
        step_next = take ? ctrl.tgt : step_reg + dpd_pkg::STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= dpd_pkg::ST_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

@@ design/dpd_div.sv @@
module dpd_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dpd_pkg::DIVN_W-1:0]    num,
    input  logic                          num_neg,
    input  logic [dpd_pkg::DIVD_W-1:0]    den,
    output logic                          busy,
    output logic [dpd_pkg::DIVN_W-1:0]    quo,
    output logic                          quo_neg
);

    // quo_reg holds the numerator bits not yet used, quotient bits shift in
    logic [dpd_pkg::DIVN_W-1:0]     quo_reg;
    logic [dpd_pkg::DIVN_W-1:0]     quo_next;
    logic [dpd_pkg::DIVD_W-1:0]     rem_reg;
    logic [dpd_pkg::DIVD_W-1:0]     rem_next;
    logic [dpd_pkg::DIVD_W-1:0]     den_reg;
    logic                           neg_reg;
    logic [dpd_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [dpd_pkg::DIV_CNT_W-1:0]  cnt_next;

    assign busy    = (cnt_reg != '0);
    assign quo     = quo_reg;
    assign quo_neg = neg_reg;

    // Restoring division, DIV_BITS quotient bits per cycle
    always_comb
    begin
        logic [dpd_pkg::DIVD_W:0]    t;
        logic [dpd_pkg::DIVD_W-1:0]  r;
        logic [dpd_pkg::DIVN_W-1:0]  q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < dpd_pkg::DIV_BITS; i++)
        begin
            t = {r, q[dpd_pkg::DIVN_W-1]};
            q = {q[dpd_pkg::DIVN_W-2:0], 1'b0};
            if (t >= {1'b0, den_reg})
            begin
                t    = t - {1'b0, den_reg};
                q[0] = 1'b1;
            end
            r = t[dpd_pkg::DIVD_W-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = dpd_pkg::DIV_CNT_W'(dpd_pkg::DIV_STEPS);
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - dpd_pkg::DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num_neg;
        end
        else if (busy)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

endmodule

@@ design/dpd_dpath.sv @@
module dpd_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dpd_pkg::cfg_t                      cfg,
    input  logic [dpd_pkg::OP_W-1:0]           op,
    input  logic                               in_valid,
    input  logic [dpd_pkg::DIST_W-1:0]         distance_cm,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [dpd_pkg::SPEED_W-1:0]        drive_speed,
    output logic [dpd_pkg::DIR_W-1:0]          drive_direction,
    output logic signed [dpd_pkg::CV_W-1:0]    control_value,
    output logic                               div_busy,
    output logic                               out_free
);

    localparam int MUL_W = dpd_pkg::MUL_A_W + dpd_pkg::MUL_B_W;
    localparam int IW_W  = dpd_pkg::INT_W + 4;
    localparam int MAG_W = dpd_pkg::CV_W - 1;

    // Loop state
    logic signed [dpd_pkg::INT_W-1:0]   int_reg;
    logic signed [dpd_pkg::INT_W-1:0]   int_next;
    logic [dpd_pkg::DIST_W-1:0]         prev_reg;
    logic [dpd_pkg::DIST_W-1:0]         prev_next;

    // Working registers
    logic [dpd_pkg::DIST_W-1:0]         dist_reg;
    logic signed [dpd_pkg::ERR_W-1:0]   err_reg;
    logic signed [dpd_pkg::ERR_W-1:0]   diff_reg;
    logic signed [dpd_pkg::PROD_W-1:0]  prod_reg;
    logic signed [dpd_pkg::P_W-1:0]     p_reg;
    logic signed [dpd_pkg::SUM_W-1:0]   sum_reg;
    logic signed [dpd_pkg::SUM_W-1:0]   sum_next;

    // Output register
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [dpd_pkg::SPEED_W-1:0]        speed_reg;
    logic [dpd_pkg::DIR_W-1:0]          dir_reg;
    logic signed [dpd_pkg::CV_W-1:0]    cv_reg;

    logic                               load_in;
    logic                               load_out;
    logic [dpd_pkg::PER_W-1:0]          per_eff;

    logic signed [dpd_pkg::MUL_A_W-1:0] mul_a;
    logic signed [dpd_pkg::MUL_B_W-1:0] mul_b;
    logic signed [MUL_W-1:0]            mul_full;

    logic                               div_start;
    logic [dpd_pkg::PROD_W-1:0]         prod_abs;
    logic [dpd_pkg::DIVD_W-1:0]         div_den;
    logic [dpd_pkg::DIVN_W-1:0]         div_q;
    logic                               div_q_neg;

    logic signed [IW_W-1:0]             int_wide;
    logic [dpd_pkg::CLAMP_W-1:0]        s_abs;
    logic [MAG_W-1:0]                   cv_mag;
    logic signed [dpd_pkg::CV_W-1:0]    cv_val;
    logic [dpd_pkg::SPEED_W-1:0]        extra;
    logic [dpd_pkg::SPEED_W-1:0]        speed_val;
    logic [dpd_pkg::DIR_W-1:0]          dir_val;

    assign out_free  = !out_valid_reg || out_ready;
    assign load_in   = (op == dpd_pkg::OP_LOAD) && in_valid;
    assign load_out  = ((op == dpd_pkg::OP_OUT) || (op == dpd_pkg::OP_OFF)) && out_free;
    assign per_eff   = (cfg.period_ms == '0) ? dpd_pkg::PER_W'(1) : cfg.period_ms;

    assign out_valid       = out_valid_reg;
    assign drive_speed     = speed_reg;
    assign drive_direction = dir_reg;
    assign control_value   = cv_reg;

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            dpd_pkg::OP_MUL_IE:
            begin
                mul_a = {{(dpd_pkg::MUL_A_W-dpd_pkg::GAIN_W){1'b0}}, cfg.gain_i};
                mul_b = err_reg;
            end
            dpd_pkg::OP_MUL_XP:
            begin
                mul_a = prod_reg[dpd_pkg::MUL_A_W-1:0];
                mul_b = {{(dpd_pkg::MUL_B_W-dpd_pkg::PER_W){1'b0}}, per_eff};
            end
            dpd_pkg::OP_MUL_P:
            begin
                mul_a = {{(dpd_pkg::MUL_A_W-dpd_pkg::GAIN_W){1'b0}}, cfg.gain_p};
                mul_b = err_reg;
            end
            dpd_pkg::OP_MUL_DD:
            begin
                mul_a = {{(dpd_pkg::MUL_A_W-dpd_pkg::GAIN_W){1'b0}}, cfg.gain_d};
                mul_b = diff_reg;
            end
            dpd_pkg::OP_MUL_XK:
            begin
                mul_a = prod_reg[dpd_pkg::MUL_A_W-1:0];
                mul_b = dpd_pkg::MUL_B_W'(dpd_pkg::DIV_CONST);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Divider feed: magnitude of the product, sign carried alongside
    assign div_start = (op == dpd_pkg::OP_DIV_I) || (op == dpd_pkg::OP_DIV_D);
    assign prod_abs  = prod_reg[dpd_pkg::PROD_W-1] ? -prod_reg : prod_reg;
    assign div_den   = (op == dpd_pkg::OP_DIV_I) ? dpd_pkg::DIVD_W'(dpd_pkg::DIV_CONST)
                                                 : per_eff;

    dpd_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num     (prod_abs[dpd_pkg::DIVN_W-1:0]),
        .num_neg (prod_reg[dpd_pkg::PROD_W-1]),
        .den     (div_den),
        .busy    (div_busy),
        .quo     (div_q),
        .quo_neg (div_q_neg)
    );

    // Integral update with saturation at the register bounds
    always_comb
    begin
        int_wide = div_q_neg ? IW_W'(int_reg) - IW_W'(div_q) : IW_W'(int_reg) + IW_W'(div_q);
        int_next = int_reg;
        if (op == dpd_pkg::OP_INT_ACC)
        begin
            if (int_wide[IW_W-1:dpd_pkg::INT_W-1] == '0
                || int_wide[IW_W-1:dpd_pkg::INT_W-1] == '1)
            begin
                int_next = int_wide[dpd_pkg::INT_W-1:0];
            end
            else if (int_wide[IW_W-1])
            begin
                int_next = {1'b1, {(dpd_pkg::INT_W-1){1'b0}}};
            end
            else
            begin
                int_next = {1'b0, {(dpd_pkg::INT_W-1){1'b1}}};
            end
        end
    end

    // Sum accumulation and clamp
    always_comb
    begin
        case (op)
            dpd_pkg::OP_SUM_PI:
                sum_next = dpd_pkg::SUM_W'(p_reg) + dpd_pkg::SUM_W'(int_reg);
            dpd_pkg::OP_SUM_D:
                sum_next = div_q_neg ? sum_reg + dpd_pkg::SUM_W'(div_q)
                                     : sum_reg - dpd_pkg::SUM_W'(div_q);
            dpd_pkg::OP_CLAMP:
            begin
                if (sum_reg > dpd_pkg::OUT_LIMIT)
                    sum_next = dpd_pkg::OUT_LIMIT;
                else if (sum_reg < dpd_pkg::OUT_LIMIT_N)
                    sum_next = dpd_pkg::OUT_LIMIT_N;
                else
                    sum_next = sum_reg;
            end
            default:
                sum_next = sum_reg;
        endcase
    end

    // Result formatting from the clamped sum
    always_comb
    begin
        s_abs  = sum_reg[dpd_pkg::SUM_W-1] ? -sum_reg[dpd_pkg::CLAMP_W-1:0]
                                           : sum_reg[dpd_pkg::CLAMP_W-1:0];
        cv_mag = s_abs[dpd_pkg::FRAC_DROP +: MAG_W];
        cv_val = sum_reg[dpd_pkg::SUM_W-1] ? -{1'b0, cv_mag} : {1'b0, cv_mag};
        extra  = cv_mag[MAG_W-1 -: dpd_pkg::SPEED_W];
        if (extra > dpd_pkg::SPEED_W'(dpd_pkg::EXTRA_MAX))
            speed_val = dpd_pkg::SPEED_W'(dpd_pkg::BASE_SPEED + dpd_pkg::EXTRA_MAX);
        else
            speed_val = dpd_pkg::SPEED_W'(dpd_pkg::BASE_SPEED) + extra;
        if (err_reg > 0)
            dir_val = dpd_pkg::DIR_FWD;
        else if (err_reg < 0)
            dir_val = dpd_pkg::DIR_BACK;
        else
        begin
            dir_val   = dpd_pkg::DIR_STOP;
            speed_val = '0;
        end
    end

    always_comb
    begin
        prev_next = prev_reg;
        if (load_out && (op == dpd_pkg::OP_OUT))
            prev_next = dist_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_reg       <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            int_reg       <= int_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            dist_reg <= distance_cm;
            err_reg  <= $signed({1'b0, cfg.target_distance}) - $signed({1'b0, distance_cm});
            diff_reg <= $signed({1'b0, distance_cm}) - $signed({1'b0, prev_reg});
        end
        if (op == dpd_pkg::OP_MUL_IE || op == dpd_pkg::OP_MUL_XP
            || op == dpd_pkg::OP_MUL_DD || op == dpd_pkg::OP_MUL_XK)
        begin
            prod_reg <= mul_full[dpd_pkg::PROD_W-1:0];
        end
        if (op == dpd_pkg::OP_MUL_P)
        begin
            p_reg <= mul_full[dpd_pkg::P_W-1:0];
        end
        sum_reg <= sum_next;
        if (load_out)
        begin
            if (op == dpd_pkg::OP_OUT)
            begin
                speed_reg <= speed_val;
                dir_reg   <= dir_val;
                cv_reg    <= cv_val;
            end
            else
            begin
                speed_reg <= '0;
                dir_reg   <= dpd_pkg::DIR_STOP;
                cv_reg    <= '0;
            end
        end
    end

endmodule

@@ design/distance_pid_drive.sv @@
// PID distance keeper with derivative on measurement. Each sample item carries one
// distance (cm, Q10.6); each result item carries the PWM duty, the direction and the
// clamped control value (Q9.8). One item is worked at a time by a microprogram that
// steps a shared 34x17 multiplier and a 2-bit-per-cycle divider: with the loop
// enabled an item runs through both divisions (integral by 1000, derivative by the
// period), which take most of the time from acceptance until the next sample can be
// taken; with the loop disabled an item skips the arithmetic and yields a zero
// result. The next sample is taken while a finished result still waits in the
// output register. Registers (APB, byte address 4*i): target_distance, gain_p,
// gain_i, gain_d, period_ms, run_enable; write them only while no item is in flight.
`include "assert_macros.svh"

module distance_pid_drive (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dpd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [dpd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dpd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    dpd_sample_if.sink                      sample,
    dpd_result_if.source                    result
);

    dpd_pkg::cfg_t     cfg;
    dpd_pkg::ctrl_t    ctrl;
    dpd_pkg::status_t  stat;
    logic              div_busy;
    logic              out_free;

    dpd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer status inputs
    assign stat = '{in_valid: sample.valid, enabled: cfg.run_enable,
                    div_busy: div_busy, out_free: out_free};

    dpd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign sample.ready = (ctrl.op == dpd_pkg::OP_LOAD);

    dpd_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .op              (ctrl.op),
        .in_valid        (sample.valid),
        .distance_cm     (sample.distance_cm),
        .out_ready       (result.ready),
        .out_valid       (result.valid),
        .drive_speed     (result.drive_speed),
        .drive_direction (result.drive_direction),
        .control_value   (result.control_value),
        .div_busy        (div_busy),
        .out_free        (out_free)
    );

    // Checks
    logic in_fire;
    logic off_zero;

    assign in_fire  = sample.valid && sample.ready;
    assign off_zero = (result.drive_speed == '0) && (result.control_value == '0)
                      && (result.drive_direction == dpd_pkg::DIR_STOP);

    `ASSERT_NXT(a_one_item, clk, rst_n, in_fire, !sample.ready)
    `ASSERT_IMP(a_div_idle_on_load, clk, rst_n, in_fire, !div_busy)
    `ASSERT_IMP(a_off_result_zero, clk, rst_n, $rose(result.valid) && !cfg.run_enable, off_zero)

endmodule

@@ tb/sv/distance_pid_drive_test.sv @@
`timescale 1ns / 1ps

module distance_pid_drive_test;
    import dpd_pkg::*;

    // Integrator bounds, output clamp and helpers for steering the integrator
    localparam longint INTEG_HI      = 64'sd549755813887;
    localparam longint INTEG_LO      = -64'sd549755813888;
    localparam longint SUM_LIMIT     = 64'sd4177920;
    localparam longint INTEG_NEAR    = 64'sd100000;
    localparam longint RECENTER_GAIN = 64'sd67042;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int PLAN_N = 30;

    typedef struct packed {
        logic [SPEED_W-1:0]       speed;
        logic [DIR_W-1:0]         direction;
        logic signed [CV_W-1:0]   control_value;
    } drive_cmd_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_KNOWN} row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [REG_IDX_W-1:0]   idx;
        logic [APB_DATA_W-1:0]  value;
        drive_cmd_t             known;
    } plan_row_t;

    localparam drive_cmd_t HALTED     = '{8'd0, DIR_STOP, 17'sd0};
    localparam drive_cmd_t HALTED_NEG = '{8'd0, DIR_STOP, -17'sd65280};
    localparam drive_cmd_t FULL_FWD   = '{8'd255, DIR_FWD, 17'sd65280};
    localparam drive_cmd_t FULL_BACK  = '{8'd255, DIR_BACK, -17'sd65280};

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0]    pwdata;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;

    dpd_sample_if sample_ch ();
    dpd_result_if result_ch ();

    distance_pid_drive dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch),
        .result  (result_ch)
    );

    // Register image and controller state kept alongside the block
    cfg_t        ctl_cfg;
    longint      integ_sum;
    logic [DIST_W-1:0] last_dist;

    drive_cmd_t  pending_drive[$];
    int          fault_count = 0;
    int          items_sent = 0;
    bit          steady = 1'b0;

    // Directed register writes and items: typed results where they are obvious, predicted otherwise
    plan_row_t plan_rows [PLAN_N] = '{
        '{ROW_KNOWN, REG_TARGET, 32'd0,          HALTED},
        '{ROW_KNOWN, REG_TARGET, 32'd65535,      HALTED},
        '{ROW_CFG,   REG_ENABLE, 32'd1,          HALTED},
        '{ROW_KNOWN, REG_TARGET, 32'd3200,       HALTED_NEG},
        '{ROW_KNOWN, REG_TARGET, 32'd3200,       HALTED},
        '{ROW_ITEM,  REG_TARGET, 32'd0,          HALTED},
        '{ROW_ITEM,  REG_TARGET, 32'd65535,      HALTED},
        '{ROW_ITEM,  REG_TARGET, 32'd3201,       HALTED},
        '{ROW_CFG,   REG_PERIOD, 32'd0,          HALTED},
        '{ROW_ITEM,  REG_TARGET, 32'd3100,       HALTED},
        '{ROW_CFG,   REG_PERIOD, 32'd1023,       HALTED},
        '{ROW_ITEM,  REG_TARGET, 32'd5000,       HALTED},
        '{ROW_CFG,   REG_SPARE_A, 32'hFFFF_FFFF, HALTED},
        '{ROW_ITEM,  REG_TARGET, 32'd4000,       HALTED},
        '{ROW_CFG,   REG_GAIN_P, 32'hFFFF_FFFF,  HALTED},
        '{ROW_CFG,   REG_GAIN_I, 32'd0,          HALTED},
        '{ROW_CFG,   REG_GAIN_D, 32'd0,          HALTED},
        '{ROW_KNOWN, REG_TARGET, 32'd0,          FULL_FWD},
        '{ROW_KNOWN, REG_TARGET, 32'd65535,      FULL_BACK},
        '{ROW_CFG,   REG_TARGET, 32'd0,          HALTED},
        '{ROW_ITEM,  REG_TARGET, 32'd0,          HALTED},
        '{ROW_CFG,   REG_TARGET, 32'd65535,      HALTED},
        '{ROW_ITEM,  REG_TARGET, 32'd65535,      HALTED},
        '{ROW_CFG,   REG_GAIN_D, 32'd65535,      HALTED},
        '{ROW_ITEM,  REG_TARGET, 32'd0,          HALTED},
        '{ROW_CFG,   REG_ENABLE, 32'd0,          HALTED},
        '{ROW_KNOWN, REG_TARGET, 32'd1234,       HALTED},
        '{ROW_CFG,   REG_ENABLE, 32'hFFFF_FFFF,  HALTED},
        '{ROW_ITEM,  REG_TARGET, 32'd1234,       HALTED},
        '{ROW_CFG,   REG_SPARE_B, 32'd0,         HALTED}
    };

    always #1 clk = ~clk;

    // One control step: P on error, saturating I, D on measurement
    function automatic drive_cmd_t compute_drive(input logic [DIST_W-1:0] meas);
        drive_cmd_t cmd;
        longint per, err, p_term, i_step, d_term, total, cv, mag, extra;
        cmd = HALTED;
        if (!ctl_cfg.run_enable)
            return cmd;
        per = (ctl_cfg.period_ms == '0) ? 64'sd1 : longint'(ctl_cfg.period_ms);
        err = longint'(ctl_cfg.target_distance) - longint'(meas);
        p_term = longint'(ctl_cfg.gain_p) * err;

        i_step = (longint'(ctl_cfg.gain_i) * err * per) / DIV_CONST;
        integ_sum = integ_sum + i_step;
        if (integ_sum > INTEG_HI)
            integ_sum = INTEG_HI;
        if (integ_sum < INTEG_LO)
            integ_sum = INTEG_LO;

        d_term = -((longint'(ctl_cfg.gain_d) * (longint'(meas) - longint'(last_dist))
                   * DIV_CONST) / per);
        last_dist = meas;

        total = p_term + integ_sum + d_term;
        if (total > SUM_LIMIT)
            total = SUM_LIMIT;
        if (total < -SUM_LIMIT)
            total = -SUM_LIMIT;
        cv = total / 64;

        mag = (cv < 0) ? -cv : cv;
        extra = mag / 256;
        if (extra > EXTRA_MAX)
            extra = EXTRA_MAX;
        cmd.control_value = cv[CV_W-1:0];
        cmd.speed = SPEED_W'(BASE_SPEED + extra);
        if (err > 0)
            cmd.direction = DIR_FWD;
        else if (err < 0)
            cmd.direction = DIR_BACK;
        else
        begin
            cmd.direction = DIR_STOP;
            cmd.speed = '0;
        end
        return cmd;
    endfunction

    function automatic logic [APB_DATA_W-1:0] reg_image(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_TARGET: return APB_DATA_W'(ctl_cfg.target_distance);
            REG_GAIN_P: return APB_DATA_W'(ctl_cfg.gain_p);
            REG_GAIN_I: return APB_DATA_W'(ctl_cfg.gain_i);
            REG_GAIN_D: return APB_DATA_W'(ctl_cfg.gain_d);
            REG_PERIOD: return APB_DATA_W'(ctl_cfg.period_ms);
            REG_ENABLE: return APB_DATA_W'(ctl_cfg.run_enable);
            default:    return '0;
        endcase
    endfunction

    // APB read, data taken mid access cycle
    task automatic check_register(input logic [REG_IDX_W-1:0] idx);
        logic [APB_DATA_W-1:0] want, got;
        want = reg_image(idx);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
        begin
            $display("%0t: register %0d read expected %h, got %h", $time, idx, want, got);
            fault_count++;
        end
    endtask

    // APB write; the image follows with the field masks applied and mapped registers are read back
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_TARGET: ctl_cfg.target_distance = value[DIST_W-1:0];
            REG_GAIN_P: ctl_cfg.gain_p = value[GAIN_W-1:0];
            REG_GAIN_I: ctl_cfg.gain_i = value[GAIN_W-1:0];
            REG_GAIN_D: ctl_cfg.gain_d = value[GAIN_W-1:0];
            REG_PERIOD: ctl_cfg.period_ms = value[PER_W-1:0];
            REG_ENABLE: ctl_cfg.run_enable = value[0];
            default: ;
        endcase
        if (idx <= REG_ENABLE)
            check_register(idx);
    endtask

    // Offer one distance item, predict its drive command on acceptance
    task automatic send_distance(input logic [DIST_W-1:0] meas, input bit known_given,
                                 input drive_cmd_t known);
        drive_cmd_t pred;
        if (!steady)
        begin
            while ($urandom_range(99) < 21)
            begin
                sample_ch.valid <= 1'b0;
                sample_ch.distance_cm <= DIST_W'($urandom);
                @(posedge clk);
            end
        end
        sample_ch.valid <= 1'b1;
        sample_ch.distance_cm <= meas;
        do @(posedge clk); while (!sample_ch.ready);
        pred = compute_drive(meas);
        pending_drive.push_back(known_given ? known : pred);
        items_sent++;
    endtask

    // Stop offering items and let every outstanding result come back
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [PER_W-1:0] pick_period();
        case ($urandom_range(9))
            0: return '0;
            1: return PER_W'(1);
            2: return PER_W'(1000);
            3: return '1;
            default: return PER_W'($urandom_range(1, 1023));
        endcase
    endfunction

    // Outside wild phases mostly near the setpoint or the last sample, with some zero error and extremes
    function automatic logic [DIST_W-1:0] pick_distance(input bit wild);
        int r, t;
        r = $urandom_range(99);
        if (r < 8)
            return ctl_cfg.target_distance;
        if (r < 12)
            return '0;
        if (r < 16)
            return '1;
        if (wild || r < 40)
            return DIST_W'($urandom);
        if (r < 75)
            t = int'(ctl_cfg.target_distance) + int'($urandom_range(0, 3000)) - 1500;
        else
            t = int'(last_dist) + int'($urandom_range(0, 100)) - 50;
        if (t < 0)
            t = 0;
        if (t > 65535)
            t = 65535;
        return DIST_W'(t);
    endfunction

    // New setting for a phase; upper data bits carry junk to exercise masking
    task automatic random_setup(input bit wild);
        logic [31:0] junk;
        logic [DIST_W-1:0] tgt;
        junk = $urandom;
        tgt = wild ? pick_word() : DIST_W'($urandom_range(1000, 64000));
        reg_write(REG_TARGET, {junk[31:16], tgt});
        reg_write(REG_GAIN_P, {junk[15:0], wild ? pick_word() : GAIN_W'($urandom_range(0, 600))});
        reg_write(REG_GAIN_I, {junk[31:16], wild ? pick_word() : GAIN_W'($urandom_range(0, 64))});
        reg_write(REG_GAIN_D, {junk[15:0], wild ? pick_word() : GAIN_W'($urandom_range(0, 600))});
        reg_write(REG_PERIOD, {junk[31:10], pick_period()});
        reg_write(REG_ENABLE, {junk[31:1], 1'($urandom_range(99) < 85)});
        if ($urandom_range(3) == 0)
            reg_write($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    endtask

    task automatic run_phase(input bit wild, input int count);
        wait_drained();
        random_setup(wild);
        for (int n = 0; n < count; n++)
            send_distance(pick_distance(wild), 1'b0, HALTED);
    endtask

    // Drive the integrator back near zero so later phases are not all clamped
    task automatic recenter_integral();
        longint step_err;
        int guard;
        guard = 0;
        if (integ_sum <= INTEG_NEAR && integ_sum >= -INTEG_NEAR)
            return;
        wait_drained();
        reg_write(REG_TARGET, 32'd32768);
        reg_write(REG_GAIN_I, 32'd65535);
        reg_write(REG_PERIOD, 32'd1023);
        reg_write(REG_ENABLE, 32'd1);
        while ((integ_sum > INTEG_NEAR || integ_sum < -INTEG_NEAR) && guard < 400)
        begin
            step_err = -integ_sum / RECENTER_GAIN;
            if (step_err > 32767)
                step_err = 32767;
            if (step_err < -32767)
                step_err = -32767;
            send_distance(DIST_W'(64'sd32768 - step_err), 1'b0, HALTED);
            guard++;
        end
    endtask

    // Result side: random back-pressure and in-order comparison
    always @(posedge clk)
    begin : result_check
        drive_cmd_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_drive.size() == 0)
            begin
                $display("%0t: result item with none outstanding: speed %0d dir %0d value %0d",
                         $time, result_ch.drive_speed, result_ch.drive_direction,
                         result_ch.control_value);
                fault_count++;
            end
            else
            begin
                want = pending_drive.pop_front();
                if (result_ch.drive_speed !== want.speed)
                begin
                    $display("%0t: drive_speed expected %0d, got %0d", $time, want.speed,
                             result_ch.drive_speed);
                    fault_count++;
                end
                if (result_ch.drive_direction !== want.direction)
                begin
                    $display("%0t: drive_direction expected %0d, got %0d", $time,
                             want.direction, result_ch.drive_direction);
                    fault_count++;
                end
                if (result_ch.control_value !== want.control_value)
                begin
                    $display("%0t: control_value expected %0d, got %0d", $time,
                             want.control_value, result_ch.control_value);
                    fault_count++;
                end
            end
        end
        result_ch.ready <= steady || ($urandom_range(99) >= 21);
    end

    // Run limit
    initial
    begin
        #3_000_000;
        $display("distance_pid_drive regression: fail");
        $finish;
    end

    initial
    begin
        bit wild;
        int phase;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.distance_cm = '0;
        result_ch.ready = 1'b0;
        ctl_cfg = '{16'd3200, 16'd128, 16'd26, 16'd256, 10'd100, 1'b0};
        integ_sum = 0;
        last_dist = '0;
        phase = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values
        for (int i = REG_TARGET; i <= REG_ENABLE; i++)
            check_register(REG_IDX_W'(i));

        // Directed part
        for (int i = 0; i < PLAN_N; i++)
        begin
            if (plan_rows[i].kind == ROW_CFG)
            begin
                wait_drained();
                reg_write(plan_rows[i].idx, plan_rows[i].value);
            end
            else
                send_distance(plan_rows[i].value[DIST_W-1:0], plan_rows[i].kind == ROW_KNOWN,
                              plan_rows[i].known);
        end

        // Random phases; one long phase with no idling on either side
        while (items_sent < 1080)
        begin
            wild = ($urandom_range(3) == 0);
            steady = (phase == 4);
            run_phase(wild, steady ? 150 :
                      (wild ? int'($urandom_range(5, 30)) : int'($urandom_range(20, 80))));
            steady = 1'b0;
            recenter_integral();
            phase++;
        end

        // Integrator driven into its upper bound, then into its lower bound
        wait_drained();
        reg_write(REG_GAIN_P, {16'h0, pick_word()});
        reg_write(REG_GAIN_D, {16'h0, pick_word()});
        reg_write(REG_GAIN_I, 32'd65535);
        reg_write(REG_PERIOD, 32'd1023);
        reg_write(REG_TARGET, 32'd65535);
        reg_write(REG_ENABLE, 32'd1);
        repeat (140)
            send_distance(DIST_W'($urandom_range(0, 63)), 1'b0, HALTED);
        wait_drained();
        reg_write(REG_TARGET, 32'd0);
        repeat (270)
            send_distance(DIST_W'($urandom_range(65472, 65535)), 1'b0, HALTED);

        // Drain and close
        wait_drained();
        repeat (64) @(posedge clk);
        if (fault_count == 0)
            $display("distance_pid_drive regression: pass");
        else
            $display("distance_pid_drive regression: fail");
        $finish;
    end

endmodule
